[design/psa_pkg.sv]
// ----------------------------------------------------------------------------
// psa_pkg
// Shared types, widths and codes of the pairwise spatial spectrum accumulator.
// ----------------------------------------------------------------------------
package psa_pkg;

  localparam int unsigned MaxPairsDefault = 64;

  localparam int unsigned CovW    = 32;                 // Q16.16 covariances
  localparam int unsigned SteerW  = 16;                 // Q1.15 steering phase
  localparam int unsigned TrW     = CovW + 1;           // r11 + r22
  localparam int unsigned CrossW  = CovW + SteerW + 1;  // Re(r12 * steer), Q.31
  localparam int unsigned DivW    = 52;                 // num / den at scale 2^-31
  localparam int unsigned MagW    = DivW - 1;           // |num|, |den|
  localparam int unsigned RatioW  = 32;                 // Q16.16 pair ratio
  localparam int unsigned QuotW   = RatioW - 1;         // quotient bits after range check
  localparam int unsigned FracW   = 16;
  localparam int unsigned SatSh   = 15;                 // |num| >= |den| << 15 overflows
  localparam int unsigned SumW    = 40;                 // Q24.16 sum

  localparam logic signed [RatioW-1:0] RatioMax = {1'b0, {(RatioW-1){1'b1}}};
  localparam logic signed [RatioW-1:0] RatioMin = {1'b1, {(RatioW-1){1'b0}}};
  localparam logic signed [SumW-1:0]   SumMax   = {1'b0, {(SumW-1){1'b1}}};
  localparam logic signed [SumW-1:0]   SumMin   = {1'b1, {(SumW-1){1'b0}}};

  typedef struct packed {
    logic signed [CovW-1:0]   r11_re;
    logic signed [CovW-1:0]   r22_re;
    logic signed [CovW-1:0]   r12_re;
    logic signed [CovW-1:0]   r12_im;
    logic signed [SteerW-1:0] steer_re;
    logic signed [SteerW-1:0] steer_im;
    logic                     last_pair;
  } psa_in_t;

  typedef struct packed {
    logic signed [SumW-1:0] spectrum;
    logic                   zero_denominator;
  } psa_out_t;

  // one finished pair ratio handed to the accumulator
  typedef struct packed {
    logic signed [RatioW-1:0] ratio;
    logic                     zero;
    logic                     last;
  } psa_ratio_t;

  typedef enum logic [1:0] {
    TS_IDLE,
    TS_MUL,
    TS_DIV,
    TS_ACC
  } psa_top_state_e;

  typedef enum logic [2:0] {
    DS_IDLE,
    DS_FORM,
    DS_ABS,
    DS_CHECK,
    DS_DIV,
    DS_DONE
  } psa_div_state_e;

endpackage

[design/psa_stream_if.sv]
// ----------------------------------------------------------------------------
// psa_stream_if
// Valid/ready stream channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
interface psa_stream_if #(
  parameter type T = logic
) ();

  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

[design/psa_mult.sv]
// ----------------------------------------------------------------------------
// psa_mult
// Bit-serial steered cross term: Re(r12 * steer) = r12_re*s_re - r12_im*s_im,
// one steering bit per cycle, LSB first.
// ----------------------------------------------------------------------------
module psa_mult (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic signed [psa_pkg::CovW-1:0]       cre_i,
  input  logic signed [psa_pkg::CovW-1:0]       cim_i,
  input  logic signed [psa_pkg::SteerW-1:0]     sre_i,
  input  logic signed [psa_pkg::SteerW-1:0]     sim_i,
  output logic                                  done_o,
  output logic signed [psa_pkg::CrossW-1:0]     cross_o
);
  import psa_pkg::*;

  localparam int unsigned McW  = CovW + SteerW;
  localparam int unsigned CntW = $clog2(SteerW);

  logic                     busy_q;
  logic                     done_q;
  logic [CntW-1:0]          cnt_q;
  logic signed [McW-1:0]    mcre_q, mcim_q;
  logic [SteerW-1:0]        sre_sh_q, sim_sh_q;
  logic signed [CrossW-1:0] acc_q, acc_d;
  logic signed [CrossW-1:0] term_re, term_im;
  logic                     sign_step;

  always_comb begin
    term_re   = sre_sh_q[0] ? {mcre_q[McW-1], mcre_q} : '0;
    term_im   = sim_sh_q[0] ? {mcim_q[McW-1], mcim_q} : '0;
    sign_step = (cnt_q == CntW'(SteerW - 1));
    // the steering sign bit carries weight -2^15
    if (sign_step) begin
      acc_d = acc_q - term_re + term_im;
    end else begin
      acc_d = acc_q + term_re - term_im;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (sign_step) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mcre_q   <= {{SteerW{cre_i[CovW-1]}}, cre_i};
      mcim_q   <= {{SteerW{cim_i[CovW-1]}}, cim_i};
      sre_sh_q <= sre_i;
      sim_sh_q <= sim_i;
      acc_q    <= '0;
    end else if (busy_q) begin
      mcre_q   <= mcre_q <<< 1;
      mcim_q   <= mcim_q <<< 1;
      sre_sh_q <= sre_sh_q >> 1;
      sim_sh_q <= sim_sh_q >> 1;
      acc_q    <= acc_d;
    end
  end

  assign done_o  = done_q;
  assign cross_o = acc_q;

endmodule

[design/psa_div.sv]
// ----------------------------------------------------------------------------
// psa_div
// Forms (tr + 2t) and (tr - 2t) and divides them bit-serially into a
// saturated Q16.16 ratio, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module psa_div (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic signed [psa_pkg::TrW-1:0]       tr_i,
  input  logic signed [psa_pkg::CrossW-1:0]    cross_i,
  output logic                                 done_o,
  output logic signed [psa_pkg::RatioW-1:0]    ratio_o,
  output logic                                 zero_o
);
  import psa_pkg::*;

  localparam int unsigned CntW = $clog2(QuotW);
  localparam int unsigned TrPad = DivW - TrW - SatSh;
  localparam int unsigned CrPad = DivW - CrossW - 1;

  psa_div_state_e state_q, state_d;

  logic signed [DivW-1:0] num_q, den_q;
  logic signed [DivW-1:0] tr_ext, t2_ext, num_neg, den_neg;
  logic [MagW-1:0]        an_q, ad_q;
  logic                   neg_q, num_neg_q, dz_q, sat_q;
  logic [MagW-1:0]        rem_q;
  logic [QuotW-1:0]       sh_q;
  logic [CntW-1:0]        cnt_q;
  logic signed [RatioW-1:0] ratio_q;
  logic                   zero_q;
  logic                   done_q;
  logic [MagW:0]          rem2;
  logic                   ge;
  logic [MagW:0]          rem_sub;
  logic                   ovf;
  logic                   last_bit;
  logic [RatioW-1:0]      quot_ext;

  always_comb begin
    tr_ext   = {{TrPad{tr_i[TrW-1]}}, tr_i, {SatSh{1'b0}}};
    t2_ext   = {{CrPad{cross_i[CrossW-1]}}, cross_i, 1'b0};
    num_neg  = -num_q;
    den_neg  = -den_q;
    ovf      = ({{(SatSh+1){1'b0}}, an_q} >= {1'b0, ad_q, {SatSh{1'b0}}});
    rem2     = {rem_q, sh_q[QuotW-1]};
    ge       = (rem2 >= {1'b0, ad_q});
    rem_sub  = rem2 - {1'b0, ad_q};
    last_bit = (cnt_q == CntW'(QuotW - 1));
    quot_ext = {1'b0, sh_q};
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      DS_IDLE:  if (start_i) state_d = DS_FORM;
      DS_FORM:  state_d = DS_ABS;
      DS_ABS:   state_d = DS_CHECK;
      DS_CHECK: state_d = (dz_q || ovf) ? DS_DONE : DS_DIV;
      DS_DIV:   if (last_bit) state_d = DS_DONE;
      DS_DONE:  state_d = DS_IDLE;
      default:  state_d = DS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DS_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == DS_DONE);
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      DS_IDLE: begin
        num_q <= tr_ext + t2_ext;
        den_q <= tr_ext - t2_ext;
      end
      DS_FORM: begin
        // operands were latched while idle; take magnitudes, signs and the zero check
        an_q      <= num_q[DivW-1] ? num_neg[MagW-1:0] : num_q[MagW-1:0];
        ad_q      <= den_q[DivW-1] ? den_neg[MagW-1:0] : den_q[MagW-1:0];
        neg_q     <= num_q[DivW-1] ^ den_q[DivW-1];
        num_neg_q <= num_q[DivW-1];
        dz_q      <= (den_q == '0);
      end
      DS_ABS: begin
        cnt_q <= '0;
      end
      DS_CHECK: begin
        if (dz_q) begin
          ratio_q <= num_neg_q ? RatioMin : RatioMax;
          zero_q  <= 1'b1;
          sat_q   <= 1'b1;
        end else if (ovf) begin
          ratio_q <= neg_q ? RatioMin : RatioMax;
          zero_q  <= 1'b0;
          sat_q   <= 1'b1;
        end else begin
          zero_q <= 1'b0;
          sat_q  <= 1'b0;
          // integer part below 2^15, so the top slice of |num| is below |den|
          rem_q  <= {{SatSh{1'b0}}, an_q[MagW-1:SatSh]};
          sh_q   <= {an_q[SatSh-1:0], {FracW{1'b0}}};
          cnt_q  <= '0;
        end
      end
      DS_DIV: begin
        rem_q <= ge ? rem_sub[MagW-1:0] : rem2[MagW-1:0];
        sh_q  <= {sh_q[QuotW-2:0], ge};
        cnt_q <= cnt_q + 1'b1;
      end
      DS_DONE: begin
        if (!sat_q) begin
          ratio_q <= neg_q ? -$signed(quot_ext) : $signed(quot_ext);
        end
      end
      default: begin
        cnt_q <= '0;
      end
    endcase
  end

  assign done_o  = done_q;
  assign ratio_o = ratio_q;
  assign zero_o  = zero_q;

endmodule

[design/psa_accum.sv]
// ----------------------------------------------------------------------------
// psa_accum
// Saturating ratio sum over one pair group, with the result output register.
// ----------------------------------------------------------------------------
module psa_accum #(
  parameter int unsigned MAX_PAIRS = psa_pkg::MaxPairsDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  psa_pkg::psa_ratio_t   ratio_i,
  psa_stream_if.source          out_o
);
  import psa_pkg::*;

  localparam int unsigned CntW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;

  logic signed [SumW-1:0] sum_q, sum_sat;
  logic                   zero_q;
  logic [CntW-1:0]        cnt_q;
  logic                   out_valid_q;
  psa_out_t               out_data_q;
  logic signed [SumW:0]   sum_wide;
  logic                   push, close;

  always_comb begin
    sum_wide = {sum_q[SumW-1], sum_q}
             + {{(SumW + 1 - RatioW){ratio_i.ratio[RatioW-1]}}, ratio_i.ratio};
    priority if (sum_wide[SumW] != sum_wide[SumW-1]) begin
      sum_sat = sum_wide[SumW] ? SumMin : SumMax;
    end else begin
      sum_sat = sum_wide[SumW-1:0];
    end
    ready_o = !out_valid_q || out_o.ready;
    push    = valid_i && ready_o;
    // an over-long group closes itself on its last allowed pair
    close   = ratio_i.last || (cnt_q == CntW'(MAX_PAIRS - 1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      zero_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (push && close) begin
        sum_q       <= '0;
        zero_q      <= 1'b0;
        cnt_q       <= '0;
        out_valid_q <= 1'b1;
      end else begin
        if (push) begin
          sum_q  <= sum_sat;
          zero_q <= zero_q | ratio_i.zero;
          cnt_q  <= cnt_q + 1'b1;
        end
        if (out_o.ready) begin
          out_valid_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push && close) begin
      out_data_q.spectrum         <= sum_sat;
      out_data_q.zero_denominator <= zero_q | ratio_i.zero;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_data_q;

endmodule

[design/pairwise_spatial_spectrum_accumulate_top.sv]
// ----------------------------------------------------------------------------
// pairwise_spatial_spectrum_accumulate_top
// Per-pair steered coherence ratio, summed over a group of microphone pairs.
// ----------------------------------------------------------------------------
// One pair item is worked on at a time. After the accepting edge, a bit-serial
// multiplier forms the steered cross term in 16 steps. The divider then forms
// and checks numerator and denominator, works out the 31-bit quotient (one bit
// per cycle) and applies the sign. The ratio is then handed to the accumulator,
// which updates the sum. No quotient bits are needed when the ratio saturates
// or the denominator is zero, and the divider then goes straight to its done
// step. A result item leaves only on the pair marked last or on the MAX_PAIRS-th
// pair of a group. It waits in an output register while the next pair is worked
// on, and that pair's sum update waits until the result has been taken.
module pairwise_spatial_spectrum_accumulate_top #(
  parameter int unsigned MAX_PAIRS = psa_pkg::MaxPairsDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  psa_stream_if.sink    in_i,
  psa_stream_if.source  out_o
);
  import psa_pkg::*;

  psa_top_state_e state_q, state_d;

  logic signed [TrW-1:0]    tr_q;
  logic                     last_q;
  logic                     in_fire;
  logic                     mult_done, div_start, div_done;
  logic signed [CrossW-1:0] cross_term;
  logic signed [RatioW-1:0] ratio;
  logic                     ratio_zero;
  logic                     acc_valid, acc_ready;
  psa_ratio_t               acc_item;

  always_comb begin
    state_d    = state_q;
    in_i.ready = (state_q == TS_IDLE);
    in_fire    = in_i.valid && in_i.ready;
    div_start  = 1'b0;
    acc_valid  = 1'b0;
    unique case (state_q)
      TS_IDLE: if (in_fire) state_d = TS_MUL;
      TS_MUL: begin
        if (mult_done) begin
          div_start = 1'b1;
          state_d   = TS_DIV;
        end
      end
      TS_DIV: if (div_done) state_d = TS_ACC;
      TS_ACC: begin
        acc_valid = 1'b1;
        if (acc_ready) state_d = TS_IDLE;
      end
      default: state_d = TS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= TS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      tr_q   <= {in_i.payload.r11_re[CovW-1], in_i.payload.r11_re}
              + {in_i.payload.r22_re[CovW-1], in_i.payload.r22_re};
      last_q <= in_i.payload.last_pair;
    end
  end

  psa_mult u_mult (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_fire),
    .cre_i   (in_i.payload.r12_re),
    .cim_i   (in_i.payload.r12_im),
    .sre_i   (in_i.payload.steer_re),
    .sim_i   (in_i.payload.steer_im),
    .done_o  (mult_done),
    .cross_o (cross_term)
  );

  psa_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .tr_i    (tr_q),
    .cross_i (cross_term),
    .done_o  (div_done),
    .ratio_o (ratio),
    .zero_o  (ratio_zero)
  );

  always_comb begin
    acc_item.ratio = ratio;
    acc_item.zero  = ratio_zero;
    acc_item.last  = last_q;
  end

  psa_accum #(
    .MAX_PAIRS (MAX_PAIRS)
  ) u_accum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (acc_valid),
    .ready_o (acc_ready),
    .ratio_i (acc_item),
    .out_o   (out_o)
  );

endmodule

[design/psa_checker.sv]
// ----------------------------------------------------------------------------
// psa_checker
// Port-level checks of the pair accumulator, bound to the top level.
// ----------------------------------------------------------------------------
module psa_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  psa_pkg::psa_out_t  out_data_i
);
  import psa_pkg::*;

  // a waiting result item stays up until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result item dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_data_i))
    else $error("result item changed while stalled");

  // one pair at a time: no second item straight after an accepted one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("item accepted while previous pair still in work");

  // a new result only comes out of the final step of a pair
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_ready_i))
    else $error("result item appeared while no pair was in work");

endmodule

bind pairwise_spatial_spectrum_accumulate_top psa_checker u_psa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.payload)
);

[tb/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stream test of the pairwise spatial spectrum accumulator. Pair items go in
// through a random-gap driver, and a bit-accurate predictor computes each
// steered coherence ratio and the running group sum. A monitor under random
// back-pressure compares every spectrum item with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

  import psa_pkg::*;

  localparam int unsigned GroupLimit = MaxPairsDefault;
  localparam int unsigned HoldCycles = 600;

  typedef enum int {
    PK_NOISE,
    PK_PLAIN,
    PK_BALANCED,
    PK_NEAR_ZERO,
    PK_EXTREME,
    PK_STRONG_CROSS
  } pair_kind_e;

  logic clk_i;
  logic rst_ni;

  psa_stream_if #(.T(psa_in_t))  pair_if ();
  psa_stream_if #(.T(psa_out_t)) spec_if ();

  pairwise_spatial_spectrum_accumulate_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (pair_if),
    .out_o  (spec_if)
  );

  always #6 clk_i = ~clk_i;

  // predictor state
  logic signed [SumW-1:0] group_sum;
  bit                     group_zero;
  int unsigned            group_pairs;
  psa_out_t               spectrum_q[$];

  psa_in_t     pair_q[$];
  int unsigned pairs_queued;
  int unsigned pairs_taken;
  int unsigned errors;
  logic        steady;
  logic        hold_req;
  logic        hold_served;
  int unsigned hold_left;
  psa_out_t    spec_want;

  function automatic logic signed [RatioW-1:0] steered_ratio(input psa_in_t p,
                                                             output bit zero_den);
    logic signed [63:0] r11, r22, cre, cim, sre, sim;
    logic signed [63:0] trace, cross2, num, den;
    logic [127:0]       an, ad, q;
    bit                 neg;
    zero_den = 1'b0;
    r11 = $signed(p.r11_re);
    r22 = $signed(p.r22_re);
    cre = $signed(p.r12_re);
    cim = $signed(p.r12_im);
    sre = $signed(p.steer_re);
    sim = $signed(p.steer_im);
    // both terms at a scale of 2^-31
    trace  = (r11 + r22) * 64'sd32768;
    cross2 = (cre * sre - cim * sim) * 64'sd2;
    num = trace + cross2;
    den = trace - cross2;
    if (den == 0) begin
      zero_den = 1'b1;
      return (num < 0) ? RatioMin : RatioMax;
    end
    neg = (num < 0) != (den < 0);
    an = (num < 0) ? 128'(-num) : 128'(num);
    ad = (den < 0) ? 128'(-den) : 128'(den);
    if (an >= (ad << SatSh)) return neg ? RatioMin : RatioMax;
    q = (an << FracW) / ad;
    return neg ? -$signed(q[RatioW-1:0]) : $signed(q[RatioW-1:0]);
  endfunction

  function automatic void accept_pair(input psa_in_t p);
    logic signed [RatioW-1:0] ratio;
    logic signed [SumW:0]     s;
    bit                       z;
    ratio = steered_ratio(p, z);
    group_zero = group_zero | z;
    s = group_sum + ratio;
    if (s > SumMax) s = SumMax;
    else if (s < SumMin) s = SumMin;
    group_sum = s[SumW-1:0];
    group_pairs++;
    // an overlong group closes on its own
    if (p.last_pair || group_pairs == GroupLimit) begin
      spectrum_q.push_back('{spectrum: group_sum, zero_denominator: group_zero});
      group_sum   = '0;
      group_zero  = 1'b0;
      group_pairs = 0;
    end
  endfunction

  function automatic psa_in_t make_pair(input int r11, input int r22, input int cre,
                                        input int cim, input shortint sre,
                                        input shortint sim, input bit last);
    psa_in_t p;
    p.r11_re    = r11;
    p.r22_re    = r22;
    p.r12_re    = cre;
    p.r12_im    = cim;
    p.steer_re  = sre;
    p.steer_im  = sim;
    p.last_pair = last;
    return p;
  endfunction

  function automatic int corner_word();
    int unsigned roll;
    roll = $urandom_range(2);
    if (roll == 0) return 32'h7fff_ffff;
    if (roll == 1) return 32'h8000_0000;
    return $urandom;
  endfunction

  function automatic shortint corner_steer();
    int unsigned roll;
    roll = $urandom_range(2);
    if (roll == 0) return 16'h7fff;
    if (roll == 1) return 16'h8000;
    return shortint'($urandom);
  endfunction

  function automatic pair_kind_e pick_kind();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 10) return PK_NOISE;
    if (roll < 45) return PK_PLAIN;
    if (roll < 60) return PK_BALANCED;
    if (roll < 75) return PK_NEAR_ZERO;
    if (roll < 85) return PK_EXTREME;
    return PK_STRONG_CROSS;
  endfunction

  function automatic psa_in_t random_pair(input pair_kind_e kind, input bit last);
    psa_in_t p;
    int      e, r11;
    p = make_pair($urandom, $urandom, $urandom, $urandom, shortint'($urandom),
                  shortint'($urandom), last);
    case (kind)
      PK_PLAIN: begin
        p.r11_re = $urandom_range(0, 1 << 24);
        p.r22_re = $urandom_range(0, 1 << 24);
        p.r12_re = int'($urandom_range(0, 1 << 23)) - (1 << 22);
        p.r12_im = int'($urandom_range(0, 1 << 23)) - (1 << 22);
      end
      PK_BALANCED, PK_NEAR_ZERO: begin
        // pick a quarter-turn steering so that 2t = 32768 * e exactly
        e   = int'($urandom_range(0, 1 << 30)) - (1 << 29);
        r11 = int'($urandom_range(0, 1 << 30)) - (1 << 29);
        case ($urandom_range(3))
          0: begin
            p.steer_re = 16'sd16384;  p.steer_im = '0;  p.r12_re = e;
          end
          1: begin
            p.steer_re = -16'sd16384; p.steer_im = '0;  p.r12_re = -e;
          end
          2: begin
            p.steer_re = '0;  p.steer_im = 16'sd16384;  p.r12_im = -e;
          end
          default: begin
            p.steer_re = '0;  p.steer_im = -16'sd16384; p.r12_im = e;
          end
        endcase
        p.r11_re = r11;
        // near zero: denominator of a few lsbs, ratio saturates unless e is small
        p.r22_re = e - r11 + ((kind == PK_NEAR_ZERO) ? int'($urandom_range(0, 6)) - 3 : 0);
      end
      PK_EXTREME: begin
        p.r11_re   = corner_word();
        p.r22_re   = corner_word();
        p.r12_re   = corner_word();
        p.r12_im   = corner_word();
        p.steer_re = corner_steer();
        p.steer_im = corner_steer();
      end
      PK_STRONG_CROSS: begin
        p.r11_re = $urandom_range(0, 1 << 12);
        p.r22_re = $urandom_range(0, 1 << 12);
        p.r12_re = int'($urandom) >>> 3;
        p.r12_im = int'($urandom) >>> 3;
      end
      default: ;
    endcase
    return p;
  endfunction

  task automatic queue_pair(input psa_in_t p);
    pair_q.push_back(p);
    pairs_queued++;
  endtask

  task automatic queue_groups(input int n_items);
    int left, len;
    left = n_items;
    while (left > 0) begin
      len = ($urandom_range(99) < 70) ? $urandom_range(1, 4) : $urandom_range(5, 12);
      if (len > left) len = left;
      for (int k = 0; k < len; k++) queue_pair(random_pair(pick_kind(), k == len - 1));
      left -= len;
    end
  endtask

  // every pair has a zero denominator, so each ratio saturates to one sign
  task automatic queue_long_group(input bit negative, input int len);
    int mag;
    for (int k = 0; k < len; k++) begin
      mag = $urandom_range(1, 1 << 20);
      if (negative) mag = -mag;
      queue_pair(make_pair(mag, 0, mag, $urandom, 16'sd16384, 16'sd0, k == len - 1));
    end
  endtask

  task automatic wait_drained();
    while (!(pairs_taken == pairs_queued && spectrum_q.size() == 0)) @(posedge clk_i);
  endtask

  // driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pair_if.valid   <= 1'b0;
      pair_if.payload <= '0;
    end else begin
      if (pair_if.valid && pair_if.ready) begin
        accept_pair(pair_if.payload);
        pairs_taken++;
      end
      if (!pair_if.valid || pair_if.ready) begin
        if (pair_q.size() > 0 && (steady || $urandom_range(99) >= 34)) begin
          pair_if.valid   <= 1'b1;
          pair_if.payload <= pair_q.pop_front();
        end else begin
          pair_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      spec_if.ready <= 1'b0;
      hold_left     <= 0;
      hold_served   <= 1'b0;
    end else begin
      if (spec_if.valid && spec_if.ready) begin
        if (spectrum_q.size() == 0) begin
          $error("unexpected spectrum item: spectrum %0d zero_denominator %0b",
                 spec_if.payload.spectrum, spec_if.payload.zero_denominator);
          errors++;
        end else begin
          spec_want = spectrum_q.pop_front();
          if (spec_if.payload.spectrum !== spec_want.spectrum) begin
            $error("spectrum: expected %0d actual %0d",
                   spec_want.spectrum, spec_if.payload.spectrum);
            errors++;
          end
          if (spec_if.payload.zero_denominator !== spec_want.zero_denominator) begin
            $error("zero_denominator: expected %0b actual %0b",
                   spec_want.zero_denominator, spec_if.payload.zero_denominator);
            errors++;
          end
        end
      end
      if (hold_req && !hold_served) begin
        hold_served   <= 1'b1;
        hold_left     <= HoldCycles;
        spec_if.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left     <= hold_left - 1;
        spec_if.ready <= 1'b0;
      end else begin
        spec_if.ready <= steady || ($urandom_range(99) >= 34);
      end
    end
  end

  initial begin
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    pair_if.valid   = 1'b0;
    pair_if.payload = '0;
    spec_if.ready   = 1'b0;
    steady          = 1'b0;
    hold_req        = 1'b0;
    group_sum       = '0;
    group_zero      = 1'b0;
    group_pairs     = 0;
    pairs_queued    = 0;
    pairs_taken     = 0;
    errors          = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // zero denominator with zero numerator, then with a negative numerator
    queue_pair(make_pair(0, 0, 0, 0, 16'sd0, 16'sd0, 1'b1));
    queue_pair(make_pair(-100, 0, -100, 7, 16'sd16384, 16'sd0, 1'b1));
    // no cross term: ratio of exactly one
    queue_pair(make_pair(32'h1_0000, 32'h1_0000, 0, 0, 16'sd12345, -16'sd321, 1'b1));
    // quotient overflow, positive then negative, in one group
    queue_pair(make_pair(100000, 0, 99999, 0, 16'sd16384, 16'sd0, 1'b0));
    queue_pair(make_pair(100000, 0, 100001, 0, 16'sd16384, 16'sd0, 1'b1));
    // field extremes
    queue_pair(make_pair(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
                         16'h8000, 16'h7fff, 1'b0));
    queue_pair(make_pair(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                         16'h7fff, 16'h8000, 1'b0));
    queue_pair(make_pair(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                         16'h8000, 16'h8000, 1'b1));
    // negative trace, no steering
    queue_pair(make_pair(-5, 2, 32'h1234_5678, -99, 16'sd0, 16'sd0, 1'b1));
    // ordinary negative ratio, near -3
    queue_pair(make_pair(32'h1_0000, 0, 32'h1_0000, 0, 16'sd32767, 16'sd0, 1'b1));
    // imaginary path only
    queue_pair(make_pair(32'h2_0000, 0, 0, 32'h8000, 16'sd0, -16'sd32768, 1'b1));
    // sender pauses until the block has answered everything
    wait_drained();

    queue_groups(120);
    while (pairs_taken != pairs_queued) @(posedge clk_i);

    // long receiver hold-off while single-pair groups keep coming
    hold_req <= 1'b1;
    for (int k = 0; k < 24; k++) queue_pair(random_pair(pick_kind(), 1'b1));
    while (pairs_taken != pairs_queued) @(posedge clk_i);

    steady <= 1'b1;
    queue_groups(80);
    while (pairs_taken != pairs_queued) @(posedge clk_i);
    steady <= 1'b0;

    queue_long_group(1'b0, 66);
    queue_groups(30);
    queue_long_group(1'b1, 70);
    queue_groups(30);
    wait_drained();
    repeat (150) @(posedge clk_i);

    if (errors == 0) begin
      $display("pairwise_spatial_spectrum_accumulate_top test passed");
    end else begin
      $display("pairwise_spatial_spectrum_accumulate_top test failed");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("pairwise_spatial_spectrum_accumulate_top test failed");
    $finish;
  end

endmodule
